[rtl/core/p256_pkg.sv]
// Package for the 256-bit keyless permutation: state type, constants and
// the forward and inverse round functions. No dependencies.
package p256_pkg;

  localparam int unsigned NumRoundsDef = 16;
  localparam int unsigned NumWords     = 8;
  localparam int unsigned WordW        = 32;
  localparam int unsigned BlockW       = NumWords * WordW;

  localparam logic [31:0] ROUND_CONST = 32'hf348_5763;
  localparam logic [31:0] MASK_HI2    = 32'hfcfc_fcfc;
  localparam logic [31:0] MASK_LO2    = 32'h0303_0303;
  localparam logic [31:0] MASK_HI1    = 32'hfefe_fefe;
  localparam logic [31:0] MASK_LO1    = 32'h0101_0101;

  typedef logic [NumWords-1:0][WordW-1:0] state_t;

  // Distance is always a constant at the call site.
  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic logic [31:0] byte_rot1(input logic [31:0] x);
    return ((x & MASK_HI1) >> 1) | ((x & MASK_LO1) << 7);
  endfunction

  function automatic logic [31:0] byte_rot2(input logic [31:0] x);
    return ((x & MASK_HI2) >> 2) | ((x & MASK_LO2) << 6);
  endfunction

  function automatic logic [31:0] sbox_fwd(input logic [31:0] w);
    logic [31:0] t;
    t = rotr(w, 5'd8) | ~rotr(w, 5'd24);
    t = t ^ w;
    t = t & rotr(w, 5'd16);
    t = t ^ rotr(w, 5'd24);
    return t;
  endfunction

  function automatic logic [31:0] sbox_inv(input logic [31:0] w);
    logic [31:0] t;
    t = ~rotr(w, 5'd8) & rotr(w, 5'd24);
    t = t ^ w;
    t = t & ~rotr(w, 5'd16);
    t = t ^ rotr(w, 5'd8);
    return t;
  endfunction

  function automatic state_t theta(input state_t s);
    logic [31:0] pe;
    logic [31:0] po;
    logic [31:0] de;
    logic [31:0] dodd;
    state_t      r;
    pe   = s[0] ^ s[2] ^ s[4] ^ s[6];
    po   = s[1] ^ s[3] ^ s[5] ^ s[7];
    de   = byte_rot1(byte_rot2(po) ^ pe ^ po);
    dodd = byte_rot1(byte_rot1(pe) ^ po) ^ pe;
    for (int k = 0; k < NumWords; k += 2) begin
      r[k]   = s[k] ^ de;
      r[k+1] = s[k+1] ^ dodd;
    end
    return r;
  endfunction

  function automatic state_t round_fwd(input state_t s, input logic [31:0] rc);
    state_t a;
    state_t b;
    state_t r;
    for (int k = 0; k < NumWords; k++) begin
      a[k] = sbox_fwd(s[k]);
    end
    b = theta(a);
    r[0] = rotr(b[6], 5'd7) ^ rc;
    r[1] = rotr(b[7], 5'd7);
    r[2] = rotr(b[1], 5'd2);
    r[3] = rotr(b[0], 5'd1);
    r[4] = rotr(b[2], 5'd5);
    r[5] = rotr(b[3], 5'd5);
    r[6] = b[4];
    r[7] = b[5];
    return r;
  endfunction

  function automatic state_t round_inv(input state_t s, input logic [31:0] rc);
    state_t a;
    state_t b;
    state_t r;
    a[0] = rotr(s[0] ^ rc, 5'd25);
    a[1] = rotr(s[1], 5'd25);
    a[2] = rotr(s[3], 5'd31);
    a[3] = rotr(s[2], 5'd30);
    a[4] = rotr(s[4], 5'd27);
    a[5] = rotr(s[5], 5'd27);
    a[6] = s[6];
    a[7] = s[7];
    b[0] = a[2];
    b[1] = a[3];
    b[2] = a[4];
    b[3] = a[5];
    b[4] = a[6];
    b[5] = a[7];
    b[6] = a[0];
    b[7] = a[1];
    b = theta(b);
    for (int k = 0; k < NumWords; k++) begin
      r[k] = sbox_inv(b[k]);
    end
    return r;
  endfunction

endpackage

[rtl/core/perm256_spn_forward_inverse_top.sv]
// Pipeline: one round per stage; each stage registers its round result.
// Throughput: one block per cycle while m_axis_tready is high; each stage holds one block
// and advances when the stage after it is empty or moving.
// Reset: rst_ni asynchronous, active low, clears all stage valid bits; data is not reset.
// Top level of the 256-bit permutation pipeline; depends on p256_pkg.
module perm256_spn_forward_inverse_top
  import p256_pkg::*;
#(
  parameter int unsigned NUM_ROUNDS = NumRoundsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // lane_0 [63:0], lane_1 [127:64], lane_2 [191:128], lane_3 [255:192]
  input  logic [BlockW-1:0] s_axis_tdata,
  // direction [0]
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // result_lane_0 [63:0], result_lane_1 [127:64], result_lane_2 [191:128],
  // result_lane_3 [255:192]
  output logic [BlockW-1:0] m_axis_tdata
);

  state_t                state_q [NUM_ROUNDS];
  logic [NUM_ROUNDS-1:0] dir_q;
  logic [NUM_ROUNDS-1:0] vld_q;
  logic [NUM_ROUNDS-1:0] en;
  logic [NUM_ROUNDS:0]   rdy;

  assign rdy[NUM_ROUNDS] = m_axis_tready;

  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_stage
    localparam logic [31:0] RcFwd = ROUND_CONST >> i;
    localparam logic [31:0] RcInv = ROUND_CONST >> (NUM_ROUNDS - 1 - i);

    state_t src;
    logic   src_dir;
    logic   src_vld;
    state_t state_d;

    if (i == 0) begin : g_first
      assign src     = state_t'(s_axis_tdata);
      assign src_dir = s_axis_tuser;
      assign src_vld = s_axis_tvalid;
    end else begin : g_next
      assign src     = state_q[i-1];
      assign src_dir = dir_q[i-1];
      assign src_vld = vld_q[i-1];
    end

    assign en[i]  = !vld_q[i] || rdy[i+1];
    assign rdy[i] = en[i];

    always_comb begin
      if (src_dir) begin
        state_d = round_inv(src, RcInv);
      end else begin
        state_d = round_fwd(src, RcFwd);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en[i]) begin
        vld_q[i] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i] && src_vld) begin
        state_q[i] <= state_d;
        dir_q[i]   <= src_dir;
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NUM_ROUNDS-1];
  assign m_axis_tdata  = BlockW'(state_q[NUM_ROUNDS-1]);

`ifndef ASSERT_OFF
  // A stalled stage keeps its block.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q & ~en) != '0 |=> ((vld_q & $past(vld_q & ~en)) == $past(vld_q & ~en)))
    else $error("stalled stage lost its block");

  // An accepted input lands in the first stage.
  a_input_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("input transfer did not reach first stage");

  // The first stage's direction follows the accepted input.
  a_dir_capture : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> dir_q[0] == $past(s_axis_tuser))
    else $error("direction not captured");
`endif

endmodule
